// ===== hw/rtl/snapa_pkg.sv =====
// Shared codes, field widths and parameter defaults of the snapshot array store.
package snapa_pkg;

    localparam int ACTION_W  = 2;
    localparam int INDEX_W   = 6;
    localparam int VALUE_W   = 32;
    localparam int SNAP_ID_W = 4;
    localparam int DATA_W    = 32;
    localparam int STATUS_W  = 2;

    localparam int ARRAY_LENGTH_DEF  = 64;
    localparam int MAX_SNAPSHOTS_DEF = 16;

    localparam logic [ACTION_W-1:0] ACT_SET  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SNAP = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_GET  = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_UNTAKEN = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;

endpackage

// ===== hw/rtl/snapshot_array_store.sv =====
// Versioned array: live memory, snapshot memory and the sequencer that copies between them.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  s_      | in  | s_valid / s_ready  | s_action, s_index, s_value, s_snap_id
//  m_      | out | m_valid / m_ready  | m_data, m_status
//
// One word in is worked on at a time. Set, full snap, bad get and action 3 pass
// through accept and result load; a get that reads memory adds a read step between
// the two, since the snapshot memory read is registered. A snap runs the copy between
// them, which moves one live entry per cycle through the single read port of the live memory.
// After reset a clearing pass zeroes the live memory, with s_ready low throughout.
// The snapshot memory is never cleared; rows are only read once written.
// The result sits in an output register, so a stalled m_ready holds only that word;
// the next input word is still accepted and waits for the register before loading.
module snapshot_array_store #(
    parameter int ARRAY_LENGTH  = snapa_pkg::ARRAY_LENGTH_DEF,
    parameter int MAX_SNAPSHOTS = snapa_pkg::MAX_SNAPSHOTS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [snapa_pkg::ACTION_W-1:0]   s_action,
    input  logic [snapa_pkg::INDEX_W-1:0]    s_index,
    input  logic [snapa_pkg::VALUE_W-1:0]    s_value,
    input  logic [snapa_pkg::SNAP_ID_W-1:0]  s_snap_id,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [snapa_pkg::DATA_W-1:0]     m_data,
    output logic [snapa_pkg::STATUS_W-1:0]   m_status
);

    // live memory address, snapshot memory address, snapshot counter widths
    localparam int AW    = (ARRAY_LENGTH > 1) ? $clog2(ARRAY_LENGTH) : 1;
    localparam int DEPTH = MAX_SNAPSHOTS * ARRAY_LENGTH;
    localparam int SW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(MAX_SNAPSHOTS + 1);
    // compare widths for index range and snapshot id checks
    localparam int LW    = $clog2(ARRAY_LENGTH + 1);
    localparam int IXW   = (LW > snapa_pkg::INDEX_W) ? LW : snapa_pkg::INDEX_W;
    localparam int IDW   = (CW > snapa_pkg::SNAP_ID_W) ? CW : snapa_pkg::SNAP_ID_W;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_COPY  = 3'd2;
    localparam logic [2:0] S_GETRD = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [snapa_pkg::DATA_W-1:0] live_mem [ARRAY_LENGTH];
    logic [snapa_pkg::DATA_W-1:0] snap_mem [DEPTH];

    logic [2:0]                     state_reg,    state_next;
    logic [AW-1:0]                  rd_idx_reg,   rd_idx_next;   // clear / copy walk
    logic [CW-1:0]                  taken_reg,    taken_next;
    logic [SW-1:0]                  wr_addr_reg,  wr_addr_next;  // next free snapshot entry
    logic [SW-1:0]                  get_addr_reg, get_addr_next;
    logic                           copy_wr_reg;
    logic [snapa_pkg::DATA_W-1:0]   live_rdata_reg;
    logic [snapa_pkg::DATA_W-1:0]   snap_rdata_reg;
    logic [snapa_pkg::DATA_W-1:0]   res_data_reg,   res_data_next;
    logic [snapa_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic                           res_mem_reg,    res_mem_next;  // result comes from memory
    logic                           m_valid_reg,    m_valid_next;
    logic [snapa_pkg::DATA_W-1:0]   m_data_reg,     m_data_next;
    logic [snapa_pkg::STATUS_W-1:0] m_status_reg,   m_status_next;

    logic                           live_we;
    logic [AW-1:0]                  live_waddr;
    logic [snapa_pkg::DATA_W-1:0]   live_wdata;
    logic                           in_range;
    logic                           sid_ok;
    logic                           last_idx;

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign m_status = m_status_reg;

    assign in_range = (IXW'(s_index) < IXW'(ARRAY_LENGTH));
    assign sid_ok   = (IDW'(s_snap_id) < IDW'(taken_reg));
    assign last_idx = (rd_idx_reg == AW'(ARRAY_LENGTH - 1));

    always_comb begin
        state_next      = state_reg;
        rd_idx_next     = rd_idx_reg;
        taken_next      = taken_reg;
        wr_addr_next    = copy_wr_reg ? SW'(wr_addr_reg + 1'b1) : wr_addr_reg;
        get_addr_next   = get_addr_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        res_mem_next    = res_mem_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        m_status_next   = m_status_reg;
        live_we         = 1'b0;
        live_waddr      = rd_idx_reg;
        live_wdata      = '0;

        case (state_reg)
            S_CLEAR: begin
                live_we = 1'b1;
                if (last_idx) begin
                    rd_idx_next = '0;
                    state_next  = S_IDLE;
                end else begin
                    rd_idx_next = AW'(rd_idx_reg + 1'b1);
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    res_data_next   = '0;
                    res_status_next = snapa_pkg::STAT_OK;
                    res_mem_next    = 1'b0;
                    state_next      = S_OUT;
                    case (s_action)
                        snapa_pkg::ACT_SET: begin
                            if (in_range) begin
                                live_we    = 1'b1;
                                live_waddr = AW'(s_index);
                                live_wdata = s_value;
                            end
                        end
                        snapa_pkg::ACT_SNAP: begin
                            if (taken_reg == CW'(MAX_SNAPSHOTS)) begin
                                res_status_next = snapa_pkg::STAT_FULL;
                            end else begin
                                res_data_next = snapa_pkg::DATA_W'(taken_reg);
                                taken_next    = CW'(taken_reg + 1'b1);
                                rd_idx_next   = '0;
                                state_next    = S_COPY;
                            end
                        end
                        snapa_pkg::ACT_GET: begin
                            if (!sid_ok) begin
                                res_status_next = snapa_pkg::STAT_UNTAKEN;
                            end else if (in_range) begin
                                res_mem_next  = 1'b1;
                                get_addr_next = SW'(SW'(s_snap_id) * SW'(ARRAY_LENGTH))
                                                + SW'(s_index);
                                state_next    = S_GETRD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_COPY: begin
                if (last_idx) begin
                    rd_idx_next = '0;
                    state_next  = S_OUT;
                end else begin
                    rd_idx_next = AW'(rd_idx_reg + 1'b1);
                end
            end
            S_GETRD: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_data_next   = res_mem_reg ? snap_rdata_reg : res_data_reg;
                    m_status_next = res_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            rd_idx_reg  <= '0;
            taken_reg   <= '0;
            wr_addr_reg <= '0;
            copy_wr_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_idx_reg  <= rd_idx_next;
            taken_reg   <= taken_next;
            wr_addr_reg <= wr_addr_next;
            copy_wr_reg <= (state_reg == S_COPY);
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        get_addr_reg   <= get_addr_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
        res_mem_reg    <= res_mem_next;
        m_data_reg     <= m_data_next;
        m_status_reg   <= m_status_next;
    end

    // live memory: one write port (set or clear), one registered read port (copy)
    always_ff @(posedge aclk) begin
        if (live_we) begin
            live_mem[live_waddr] <= live_wdata;
        end
        if (state_reg == S_COPY) begin
            live_rdata_reg <= live_mem[rd_idx_reg];
        end
    end

    // snapshot memory: copy writes land in the cycle after the live read; registered read port (get)
    always_ff @(posedge aclk) begin
        if (copy_wr_reg) begin
            snap_mem[wr_addr_reg] <= live_rdata_reg;
        end
        if (state_reg == S_GETRD) begin
            snap_rdata_reg <= snap_mem[get_addr_reg];
        end
    end

    a_taken_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(taken_reg) <= 32'(MAX_SNAPSHOTS))
        else $error("snapshot count beyond store size");

    a_copy_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        copy_wr_reg |-> (32'(wr_addr_reg) < 32'(DEPTH)))
        else $error("snapshot copy outside store");

    a_no_pending_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !copy_wr_reg)
        else $error("input accepted while copy write pending");

    a_snap_starts_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_action == snapa_pkg::ACT_SNAP &&
         taken_reg != CW'(MAX_SNAPSHOTS)) |=> (state_reg == S_COPY))
        else $error("snap did not start copy");

endmodule
